### sv/lora_time_on_air_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the packet air-time block
// Clocked property checks for the checker file.
// ---------------------------------------------------------------------------
`ifndef LORA_TIME_ON_AIR_CORE_DEFINES_SVH
`define LORA_TIME_ON_AIR_CORE_DEFINES_SVH

// Check a property on every rising clock edge outside reset
`define LOTA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included
`define LOTA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### sv/lota_pkg.sv
// ---------------------------------------------------------------------------
// lota_pkg
// Widths, codes and per-factor constant tables for the air-time block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lota_pkg;

   // word layout
   localparam int LEN_W      = 8;
   localparam int SF_W       = 4;
   localparam int AIR_W      = 20;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   // spreading factor codes
   localparam logic [SF_W-1:0] SF_FSK      = 4'd6;
   localparam logic [SF_W-1:0] SF_LORA_MIN = 4'd7;
   localparam logic [SF_W-1:0] SF_LORA_MAX = 4'd12;

   // arithmetic widths
   localparam int SUM_W   = 10;   // 2*len + 11 and the ceiling numerator
   localparam int RCP_W   = 14;   // reciprocal of the symbol divisor
   localparam int RCP_SH  = 16;   // reciprocal scale
   localparam int CEIL_W  = 8;    // symbol blocks
   localparam int SYM_W   = 10;
   localparam int QTR_W   = 11;
   localparam int OPND_W  = 15;   // quarter symbols after the spreading-factor shift, or the FSK bit count
   localparam int FBIT_W  = 12;   // FSK bit count
   localparam int DEN_W   = 16;
   localparam int SHIFT_W = 3;

   // formula constants
   localparam logic [SUM_W-1:0]  HDR_OFFSET     = 10'd11;  // (44 / 4)
   localparam logic [LEN_W:0]    FSK_OVERHEAD   = 9'd11;
   localparam logic [DEN_W-1:0]  FSK_DEN        = 16'd50000;
   localparam logic [QTR_W-1:0]  PREAMBLE_QTR   = 11'd49;
   localparam logic [SYM_W-1:0]  SYM_BASE       = 10'd8;
   localparam logic [DEN_W-1:0]  BASE_DEN       = 16'd15625;

   // symbol divisor minus one: 6, 7, 8, 9, then 8 and 9 with low-rate optimization
   function automatic logic [SUM_W-1:0] sf_span(input logic [SF_W-1:0] sf);
      logic [SUM_W-1:0] span;
      case (sf)
         4'd7:    span = 10'd6;
         4'd8:    span = 10'd7;
         4'd9:    span = 10'd8;
         4'd10:   span = 10'd9;
         4'd11:   span = 10'd8;
         4'd12:   span = 10'd9;
         default: span = 10'd0;
      endcase
      return span;
   endfunction

   // ceil(2^16 / divisor), exact for numerators below 1024
   function automatic logic [RCP_W-1:0] sf_recip(input logic [SF_W-1:0] sf);
      logic [RCP_W-1:0] rcp;
      case (sf)
         4'd7:    rcp = 14'd9363;
         4'd8:    rcp = 14'd8192;
         4'd9:    rcp = 14'd7282;
         4'd10:   rcp = 14'd6554;
         4'd11:   rcp = 14'd7282;
         4'd12:   rcp = 14'd6554;
         default: rcp = 14'd0;
      endcase
      return rcp;
   endfunction

   // quarter-symbol scale, capped at four
   function automatic logic [SHIFT_W-1:0] sf_shift(input logic [SF_W-1:0] sf);
      logic [SHIFT_W-1:0] sh;
      case (sf)
         4'd7:    sh = 3'd2;
         4'd8:    sh = 3'd3;
         default: sh = 3'd4;
      endcase
      return sh;
   endfunction

   // divisor, halved (truncating) once more for each factor beyond the shift cap
   function automatic logic [DEN_W-1:0] sf_den(input logic [SF_W-1:0] sf);
      logic [DEN_W-1:0] den;
      case (sf)
         4'd10:   den = BASE_DEN >> 1;
         4'd11:   den = BASE_DEN >> 2;
         4'd12:   den = BASE_DEN >> 3;
         default: den = BASE_DEN;
      endcase
      return den;
   endfunction

endpackage

`default_nettype wire

### sv/lora_time_on_air_core.sv
// ---------------------------------------------------------------------------
// Packet air-time calculator.
// Request channel (req_): one word per query, payload length and spreading
// factor. Response channel (rsp_): one word per query, in order, holding the
// air time in timer ticks; rsp_tuser flags a spreading factor outside 6..12,
// in which case the air time is zero.
// Factor 6 gives the FSK time at 50 kbit/s (truncated); factors 7..12 give
// the LoRa time at 125 kHz, rounded to the nearest tick.
// Throughput: one word per cycle while the receiver does not stall.
// The front stages select the per-factor constants, take the symbol-count
// ceiling by a reciprocal multiply and scale by the tick rate; the rest is a
// restoring divider that retires two quotient bits per stage.
// Reset empties the pipeline; no word is in flight afterwards.
// When the receiver stalls, the whole pipeline holds and req_tready drops
// only while a finished word waits at the output; with the output free,
// every stage advances, bubbles included.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lora_time_on_air_core #(
   parameter int unsigned TICKS_PER_SECOND = 1000
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // payload_length[7:0], spreading_factor[11:8], zero [15:12]
   input  wire logic [lota_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // air_time[19:0], zero [23:20]
   output logic [lota_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // bad_factor[0]
   output logic                                   rsp_tuser
);
   import lota_pkg::*;

   localparam int TICK_W     = $clog2(TICKS_PER_SECOND + 1);
   localparam int PROD_W     = OPND_W + TICK_W;
   localparam int NUM_W      = PROD_W + 1;
   localparam int NUM_PAD_W  = NUM_W + (NUM_W % 2);
   localparam int DIV_STAGES = NUM_PAD_W / 2;
   localparam logic [TICK_W-1:0] TICKS = TICK_W'(TICKS_PER_SECOND);

   // pipeline advance: the output register is free or being taken
   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // ---------------- stage 1: decode and ceiling numerator ----------------
   logic [LEN_W-1:0] req_len;
   logic [SF_W-1:0]  req_sf;
   logic [SUM_W-1:0] sum_in;
   logic             bad_in;
   logic             fsk_in;
   logic             pos_in;
   logic [SUM_W-1:0] ceil_num_in;

   assign req_len     = req_tdata[LEN_W-1:0];
   assign req_sf      = req_tdata[LEN_W +: SF_W];
   assign sum_in      = {1'b0, req_len, 1'b0} + HDR_OFFSET;
   assign fsk_in      = (req_sf == SF_FSK);
   assign bad_in      = !fsk_in && ((req_sf < SF_LORA_MIN) || (req_sf > SF_LORA_MAX));
   assign pos_in      = sum_in > SUM_W'(req_sf);
   assign ceil_num_in = sum_in - SUM_W'(req_sf) + sf_span(req_sf);

   logic             s1_vld_ff;
   logic             s1_bad_ff;
   logic             s1_fsk_ff;
   logic             s1_pos_ff;
   logic [SF_W-1:0]  s1_sf_ff;
   logic [LEN_W-1:0] s1_len_ff;
   logic [SUM_W-1:0] s1_num_ff;

   // ---------------- stage 2: reciprocal multiply, FSK bit count ----------
   logic                    s2_vld_ff;
   logic                    s2_bad_ff;
   logic                    s2_fsk_ff;
   logic                    s2_pos_ff;
   logic [SF_W-1:0]         s2_sf_ff;
   logic [SUM_W+RCP_W-1:0]  s2_prod_ff;
   logic [FBIT_W-1:0]       s2_fbits_ff;
   logic [LEN_W:0]          fsk_bytes_in;

   assign fsk_bytes_in = {1'b0, s1_len_ff} + FSK_OVERHEAD;

   // ---------------- stage 3: symbols, quarters, divisor select -----------
   logic [CEIL_W-1:0] ceil_in;
   logic [SYM_W-1:0]  sym_in;
   logic [QTR_W-1:0]  qtr_in;
   logic [OPND_W-1:0] opnd_in;
   logic [DEN_W-1:0]  den_in;
   logic [DEN_W-1:0]  half_in;

   always_comb begin
      ceil_in = s2_prod_ff[RCP_SH +: CEIL_W];
      sym_in  = s2_pos_ff ? (SYM_W'(ceil_in) * SYM_W'(5) + SYM_BASE) : SYM_BASE;
      qtr_in  = {sym_in[QTR_W-3:0], 2'b00} + PREAMBLE_QTR;
      if (s2_bad_ff) begin
         opnd_in = '0;
         den_in  = FSK_DEN;
         half_in = '0;
      end else if (s2_fsk_ff) begin
         opnd_in = OPND_W'(s2_fbits_ff);
         den_in  = FSK_DEN;
         half_in = '0;
      end else begin
         opnd_in = OPND_W'(qtr_in) << sf_shift(s2_sf_ff);
         den_in  = sf_den(s2_sf_ff);
         half_in = sf_den(s2_sf_ff) >> 1;
      end
   end

   logic              s3_vld_ff;
   logic              s3_bad_ff;
   logic [OPND_W-1:0] s3_opnd_ff;
   logic [DEN_W-1:0]  s3_den_ff;
   logic [DEN_W-1:0]  s3_half_ff;

   // ---------------- stage 4: scale by the tick rate ----------------------
   logic              s4_vld_ff;
   logic              s4_bad_ff;
   logic [PROD_W-1:0] s4_prod_ff;
   logic [DEN_W-1:0]  s4_den_ff;
   logic [DEN_W-1:0]  s4_half_ff;

   // ---------------- stage 5 and divider stages ---------------------------
   logic                 div_vld_ff [0:DIV_STAGES];
   logic                 div_bad_ff [0:DIV_STAGES];
   logic [NUM_PAD_W-1:0] div_num_ff [0:DIV_STAGES];
   logic [NUM_PAD_W-1:0] div_quo_ff [0:DIV_STAGES];
   logic [DEN_W-1:0]     div_rem_ff [0:DIV_STAGES];
   logic [DEN_W-1:0]     div_den_ff [0:DIV_STAGES];

   // valid bits of the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         s3_vld_ff     <= 1'b0;
         s4_vld_ff     <= 1'b0;
         div_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         s1_vld_ff     <= req_tvalid;
         s2_vld_ff     <= s1_vld_ff;
         s3_vld_ff     <= s2_vld_ff;
         s4_vld_ff     <= s3_vld_ff;
         div_vld_ff[0] <= s4_vld_ff;
      end
   end

   // payload of the front stages
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_bad_ff   <= bad_in;
         s1_fsk_ff   <= fsk_in;
         s1_pos_ff   <= pos_in;
         s1_sf_ff    <= req_sf;
         s1_len_ff   <= req_len;
         s1_num_ff   <= ceil_num_in;

         s2_bad_ff   <= s1_bad_ff;
         s2_fsk_ff   <= s1_fsk_ff;
         s2_pos_ff   <= s1_pos_ff;
         s2_sf_ff    <= s1_sf_ff;
         s2_prod_ff  <= (SUM_W+RCP_W)'(s1_num_ff) * (SUM_W+RCP_W)'(sf_recip(s1_sf_ff));
         s2_fbits_ff <= {fsk_bytes_in, 3'b000};

         s3_bad_ff   <= s2_bad_ff;
         s3_opnd_ff  <= opnd_in;
         s3_den_ff   <= den_in;
         s3_half_ff  <= half_in;

         s4_bad_ff   <= s3_bad_ff;
         s4_prod_ff  <= PROD_W'(s3_opnd_ff) * PROD_W'(TICKS);
         s4_den_ff   <= s3_den_ff;
         s4_half_ff  <= s3_half_ff;

         // add the rounding offset and load the divider
         div_bad_ff[0] <= s4_bad_ff;
         div_num_ff[0] <= NUM_PAD_W'(s4_prod_ff) + NUM_PAD_W'(s4_half_ff);
         div_quo_ff[0] <= '0;
         div_rem_ff[0] <= '0;
         div_den_ff[0] <= s4_den_ff;
      end
   end

   // restoring divider: two quotient bits per stage, numerator MSB first
   genvar g;
   generate
      for (g = 1; g <= DIV_STAGES; g++) begin : g_div
         logic [DEN_W:0]       step1_in;
         logic [DEN_W:0]       step2_in;
         logic                 bit1_in;
         logic                 bit2_in;
         logic [DEN_W-1:0]     rem_in;

         always_comb begin
            step1_in = {div_rem_ff[g-1], div_num_ff[g-1][NUM_PAD_W-1]};
            bit1_in  = step1_in >= {1'b0, div_den_ff[g-1]};
            if (bit1_in) begin
               step1_in = step1_in - {1'b0, div_den_ff[g-1]};
            end
            step2_in = {step1_in[DEN_W-1:0], div_num_ff[g-1][NUM_PAD_W-2]};
            bit2_in  = step2_in >= {1'b0, div_den_ff[g-1]};
            if (bit2_in) begin
               step2_in = step2_in - {1'b0, div_den_ff[g-1]};
            end
            rem_in = step2_in[DEN_W-1:0];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               div_vld_ff[g] <= 1'b0;
            end else if (adv) begin
               div_vld_ff[g] <= div_vld_ff[g-1];
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               div_bad_ff[g] <= div_bad_ff[g-1];
               div_num_ff[g] <= {div_num_ff[g-1][NUM_PAD_W-3:0], 2'b00};
               div_quo_ff[g] <= {div_quo_ff[g-1][NUM_PAD_W-3:0], bit1_in, bit2_in};
               div_rem_ff[g] <= rem_in;
               div_den_ff[g] <= div_den_ff[g-1];
            end
         end
      end
   endgenerate

   // drive the response word
   logic [AIR_W-1:0] air_time;

   generate
      if (NUM_PAD_W >= AIR_W) begin : g_air_cut
         assign air_time = div_quo_ff[DIV_STAGES][AIR_W-1:0];
      end else begin : g_air_ext
         assign air_time = AIR_W'(div_quo_ff[DIV_STAGES]);
      end
   endgenerate

   assign rsp_tvalid = div_vld_ff[DIV_STAGES];
   assign rsp_tdata  = {{(RSP_DATA_W-AIR_W){1'b0}}, air_time};
   assign rsp_tuser  = div_bad_ff[DIV_STAGES];

endmodule

`default_nettype wire

### sv/lota_checker.sv
// ---------------------------------------------------------------------------
// lota_checker
// Port-level checks for the air-time block, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lora_time_on_air_core_defines.svh"

module lota_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic [lota_pkg::REQ_DATA_W-1:0]   req_tdata,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [lota_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire logic                              rsp_tuser
);
   import lota_pkg::*;

   // stalled response and the word it carries
   logic                rsp_stall;
   logic [RSP_DATA_W:0] rsp_word;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_word  = {rsp_tuser, rsp_tdata};

   // hold a stalled response word
   `LOTA_ASSERT(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_word), "stalled word changed")

   // a bad factor carries zero air time
   `LOTA_ASSERT(a_bad_zero, rsp_tvalid && rsp_tuser |-> rsp_tdata == '0, "bad factor with nonzero air time")

   // reset leaves nothing in flight
   `LOTA_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "response valid right after reset")

   // the request side is open whenever the output register is free
   `LOTA_ASSERT(a_ready_free, !rsp_tvalid |-> req_tready, "request stalled with an empty output")

endmodule

bind lora_time_on_air_core lota_checker u_lota_checker (.*);

`default_nettype wire
